// File: rtl/sta_pkg.sv
package sta_pkg;

    // field widths
    localparam int HOURS_W    = 10;
    localparam int MS_IN_W    = 7;
    localparam int MS_W       = 6;
    localparam int WRAP_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    // working width of an hour sum before normalization
    localparam int XH_W       = 12;

    // queue between front and back
    localparam int STA_QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_WRAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MODE = 2'd1;

    localparam logic [WRAP_W-1:0] HOUR_WRAP_RST = 9'd24;

    // radix limits
    localparam logic signed [MS_IN_W-1:0] MS_LAST      = 7'sd59;
    localparam logic signed [XH_W-1:0]    ANGLE_FLOOR  = -12'sd180;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_ADD  = 1'b1
    } t_cmd;

    // item class decided by the front
    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_REJECT,
        KIND_ADD
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic signed [HOURS_W-1:0]  hours;
        logic signed [MS_IN_W-1:0]  minutes;
        logic signed [MS_IN_W-1:0]  seconds;
    } t_item;

    // hour modulo unit request / response
    typedef struct packed {
        logic                     start;
        logic signed [XH_W-1:0]   x;
        logic [WRAP_W-1:0]        wrap;
    } t_mod_req;

    typedef struct packed {
        logic               done;
        logic [WRAP_W-1:0]  rem;
    } t_mod_rsp;

endpackage

// File: rtl/sexagesimal_time_accumulator_core.sv
// Channel   Direction  Handshake                Payload
// input     in         i_valid / o_ready        i_command, i_hours_in, i_minutes_in, i_seconds_in
// result    out        o_valid / i_ready        o_hours_out, o_minutes_out, o_seconds_out,
//                                               o_rejected
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A rejected load goes from queue head through the output state to the result register; a load
// also passes one normalization step. An add runs the seconds step, a normalization for a
// minute carry out of it, the minutes step, then an hour step and normalization per hour carry out
// of the minutes and one more pair for the hour delta. Each hour change is normalized directly
// when it lands within one wrap of 0..hour_wrap-1, or clamped in angle mode. Otherwise the serial
// modulo unit takes over, one remainder bit per cycle.
// Synchronous active-low reset; no clearing pass. A two-entry queue keeps input
// transactions flowing while the back end computes or the result register stalls.
module sexagesimal_time_accumulator_core #(
    parameter int QUEUE_DEPTH = sta_pkg::STA_QUEUE_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_command,
    input  logic signed [sta_pkg::HOURS_W-1:0]    i_hours_in,
    input  logic signed [sta_pkg::MS_IN_W-1:0]    i_minutes_in,
    input  logic signed [sta_pkg::MS_IN_W-1:0]    i_seconds_in,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [sta_pkg::HOURS_W-1:0]    o_hours_out,
    output logic [sta_pkg::MS_W-1:0]              o_minutes_out,
    output logic [sta_pkg::MS_W-1:0]              o_seconds_out,
    output logic                                  o_rejected,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sta_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sta_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import sta_pkg::*;

    logic [WRAP_W-1:0]  r_hour_wrap;
    logic               r_angle_mode;
    logic               push;
    logic               pop;
    logic               q_empty;
    logic               q_full;
    t_item              front_item;
    t_item              q_item;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_wrap  <= HOUR_WRAP_RST;
            r_angle_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HOUR_WRAP:  r_hour_wrap  <= i_cfg_data[WRAP_W-1:0];
                REG_ANGLE_MODE: r_angle_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sta_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_hours_in   (i_hours_in),
        .i_minutes_in (i_minutes_in),
        .i_seconds_in (i_seconds_in),
        .i_full       (q_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    sta_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (pop),
        .o_data  (q_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sta_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (q_item),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .i_hour_wrap   (r_hour_wrap),
        .i_angle_mode  (r_angle_mode),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hours_out   (o_hours_out),
        .o_minutes_out (o_minutes_out),
        .o_seconds_out (o_seconds_out),
        .o_rejected    (o_rejected)
    );

    // results always carry normalized minutes and seconds
    a_ms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_minutes_out <= 6'd59) && (o_seconds_out <= 6'd59))
        else $error("minutes or seconds out of range");

    // stored hours stay inside the angle floor and the widest wrap
    a_hours_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hours_out >= -10'sd180) && (o_hours_out <= 10'sd510))
        else $error("hours out of range");

    // an accepted input transaction sits in the queue on the next cycle
    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !q_empty)
        else $error("accepted transaction missing from queue");

endmodule

// File: rtl/sta_fifo.sv
module sta_fifo #(
    parameter int DEPTH = sta_pkg::STA_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sta_pkg::t_item  i_data,
    input  logic            i_pop,
    output sta_pkg::t_item  o_data,
    output logic            o_empty,
    output logic            o_full
);
    import sta_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

// File: rtl/sta_front.sv
module sta_front (
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_command,
    input  logic signed [sta_pkg::HOURS_W-1:0]   i_hours_in,
    input  logic signed [sta_pkg::MS_IN_W-1:0]   i_minutes_in,
    input  logic signed [sta_pkg::MS_IN_W-1:0]   i_seconds_in,
    input  logic                                 i_full,
    output logic                                 o_push,
    output sta_pkg::t_item                       o_item
);
    import sta_pkg::*;

    logic load_bad;

    // a load needs minutes and seconds inside 0..59
    assign load_bad = (i_minutes_in < 7'sd0) || (i_minutes_in > MS_LAST) ||
                      (i_seconds_in < 7'sd0) || (i_seconds_in > MS_LAST);

    // classify the transaction
    always_comb begin
        if (t_cmd'(i_command) == CMD_ADD) begin
            o_item.kind = KIND_ADD;
        end else if (load_bad) begin
            o_item.kind = KIND_REJECT;
        end else begin
            o_item.kind = KIND_LOAD;
        end
        o_item.hours   = i_hours_in;
        o_item.minutes = i_minutes_in;
        o_item.seconds = i_seconds_in;
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// File: rtl/sta_hmod.sv
module sta_hmod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sta_pkg::t_mod_req  i_req,
    output sta_pkg::t_mod_rsp  o_rsp
);
    import sta_pkg::*;

    localparam int CNT_W = $clog2(XH_W);

    typedef enum logic [1:0] {
        HM_IDLE,
        HM_RUN,
        HM_FIX
    } t_hm_state;

    t_hm_state          r_state;
    logic [XH_W-1:0]    r_mag;
    logic [WRAP_W-1:0]  r_rem;
    logic [WRAP_W-1:0]  r_wrap;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;

    logic [XH_W-1:0]    x_mag;
    logic [WRAP_W:0]    shifted;
    logic [WRAP_W:0]    trial;
    logic [WRAP_W-1:0]  rem_step;

    // magnitude of the dividend; sign is fixed up at the end
    assign x_mag = i_req.x[XH_W-1] ? XH_W'(-i_req.x) : XH_W'(i_req.x);

    // one restoring step per cycle
    assign shifted  = {r_rem, r_mag[XH_W-1]};
    assign trial    = shifted - {1'b0, r_wrap};
    assign rem_step = (shifted >= {1'b0, r_wrap}) ? trial[WRAP_W-1:0]
                                                  : shifted[WRAP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HM_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                HM_IDLE: begin
                    if (i_req.start) begin
                        r_mag   <= x_mag;
                        r_rem   <= '0;
                        r_wrap  <= i_req.wrap;
                        r_neg   <= i_req.x[XH_W-1];
                        r_cnt   <= '0;
                        r_state <= HM_RUN;
                    end
                end
                HM_RUN: begin
                    r_rem <= rem_step;
                    r_mag <= r_mag << 1;
                    if (r_cnt == CNT_W'(XH_W - 1)) begin
                        r_state <= HM_FIX;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                HM_FIX: begin
                    // negative dividend with nonzero remainder: fold into 0..wrap-1
                    if (r_neg && (r_rem != '0)) begin
                        r_rem <= r_wrap - r_rem;
                    end
                    r_done  <= 1'b1;
                    r_state <= HM_IDLE;
                end
                default: begin
                    r_state <= HM_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// File: rtl/sta_back.sv
module sta_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sta_pkg::t_item                        i_item,
    input  logic                                  i_empty,
    output logic                                  o_pop,
    input  logic [sta_pkg::WRAP_W-1:0]            i_hour_wrap,
    input  logic                                  i_angle_mode,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [sta_pkg::HOURS_W-1:0]    o_hours_out,
    output logic [sta_pkg::MS_W-1:0]              o_minutes_out,
    output logic [sta_pkg::MS_W-1:0]              o_seconds_out,
    output logic                                  o_rejected
);
    import sta_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC,
        ST_MIN,
        ST_HB,
        ST_NORM,
        ST_WAIT,
        ST_OUT
    } t_state;

    // base-60 digit and carry count
    typedef struct packed {
        logic [2:0]       carry;
        logic [MS_W-1:0]  digit;
    } t_split;

    function automatic t_split split60(input logic signed [7:0] v);
        t_split s;
        if (v >= 8'sd120) begin
            s.digit = MS_W'(v - 8'sd120);
            s.carry = 3'd2;
        end else if (v >= 8'sd60) begin
            s.digit = MS_W'(v - 8'sd60);
            s.carry = 3'd1;
        end else if (v < -8'sd60) begin
            s.digit = MS_W'(v + 8'sd120);
            s.carry = -3'sd2;
        end else if (v < 8'sd0) begin
            s.digit = MS_W'(v + 8'sd60);
            s.carry = -3'sd1;
        end else begin
            s.digit = MS_W'(v);
            s.carry = 3'd0;
        end
        return s;
    endfunction

    t_state                     r_state;
    t_state                     r_ret;
    t_item                      r_item;
    logic signed [HOURS_W-1:0]  r_hour;
    logic [MS_W-1:0]            r_min;
    logic [MS_W-1:0]            r_sec;
    logic signed [XH_W-1:0]     r_x;
    logic signed [2:0]          r_hpend;
    logic                       r_rej;
    logic                       r_out_valid;
    logic signed [HOURS_W-1:0]  r_hours_out;
    logic [MS_W-1:0]            r_minutes_out;
    logic [MS_W-1:0]            r_seconds_out;
    logic                       r_rejected;

    logic signed [7:0]          sec_sum;
    logic signed [7:0]          min_carry_sum;
    logic signed [7:0]          min_sum;
    t_split                     ss;
    t_split                     mc;
    t_split                     ms;
    logic signed [XH_W-1:0]     hour_ext;
    logic signed [XH_W-1:0]     hour_delta;
    logic signed [XH_W-1:0]     wrap_x;
    logic signed [XH_W-1:0]     wrap2_x;
    logic signed [HOURS_W-1:0]  clamp_val;
    logic                       fast_ok;
    logic signed [XH_W-1:0]     fast_val;
    t_mod_req                   mod_req;
    t_mod_rsp                   mod_rsp;

    // seconds step: add delta, then ripple the minute carry
    assign sec_sum       = $signed({2'b00, r_sec}) +
                           $signed({r_item.seconds[MS_IN_W-1], r_item.seconds});
    assign ss            = split60(sec_sum);
    assign min_carry_sum = $signed({2'b00, r_min}) + $signed({{5{ss.carry[2]}}, ss.carry});
    assign mc            = split60(min_carry_sum);

    // minutes step
    assign min_sum = $signed({2'b00, r_min}) +
                     $signed({r_item.minutes[MS_IN_W-1], r_item.minutes});
    assign ms      = split60(min_sum);

    assign hour_ext   = {{(XH_W-HOURS_W){r_hour[HOURS_W-1]}}, r_hour};
    assign hour_delta = {{(XH_W-HOURS_W){r_item.hours[HOURS_W-1]}}, r_item.hours};

    // angle mode clamp
    always_comb begin
        if (r_x > 12'sd0) begin
            clamp_val = '0;
        end else if (r_x < ANGLE_FLOOR) begin
            clamp_val = HOURS_W'(ANGLE_FLOOR);
        end else begin
            clamp_val = HOURS_W'(r_x);
        end
    end

    // wrap mode: values within one wrap of the range resolve directly
    assign wrap_x  = $signed({3'b000, i_hour_wrap});
    assign wrap2_x = $signed({2'b00, i_hour_wrap, 1'b0});
    always_comb begin
        fast_ok  = 1'b1;
        fast_val = r_x;
        if ((r_x >= 12'sd0) && (r_x < wrap_x)) begin
            fast_val = r_x;
        end else if ((r_x >= wrap_x) && (r_x < wrap2_x)) begin
            fast_val = r_x - wrap_x;
        end else if ((r_x < 12'sd0) && (r_x >= -wrap_x)) begin
            fast_val = r_x + wrap_x;
        end else begin
            fast_ok = 1'b0;
        end
    end

    // everything else goes through the serial modulo unit
    assign mod_req.start = (r_state == ST_NORM) && !i_angle_mode &&
                           (i_hour_wrap != '0) && !fast_ok;
    assign mod_req.x     = r_x;
    assign mod_req.wrap  = i_hour_wrap;

    sta_hmod u_hmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    // sequencer, stored value and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_hour      <= '0;
            r_min       <= '0;
            r_sec       <= '0;
            r_hpend     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result register drains unless a new result replaces it this cycle
            if (r_out_valid && i_ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_item <= i_item;
                        case (i_item.kind)
                            KIND_LOAD: begin
                                r_min   <= i_item.minutes[MS_W-1:0];
                                r_sec   <= i_item.seconds[MS_W-1:0];
                                r_x     <= {{(XH_W-HOURS_W){i_item.hours[HOURS_W-1]}},
                                            i_item.hours};
                                r_rej   <= 1'b0;
                                r_ret   <= ST_OUT;
                                r_state <= ST_NORM;
                            end
                            KIND_REJECT: begin
                                r_rej   <= 1'b1;
                                r_state <= ST_OUT;
                            end
                            default: begin
                                r_rej   <= 1'b0;
                                r_state <= ST_SEC;
                            end
                        endcase
                    end
                end
                ST_SEC: begin
                    r_sec <= ss.digit;
                    r_min <= mc.digit;
                    if (mc.carry != 3'd0) begin
                        r_x     <= hour_ext + $signed({{(XH_W-3){mc.carry[2]}}, mc.carry});
                        r_ret   <= ST_MIN;
                        r_state <= ST_NORM;
                    end else begin
                        r_state <= ST_MIN;
                    end
                end
                ST_MIN: begin
                    r_min   <= ms.digit;
                    r_hpend <= $signed(ms.carry);
                    r_state <= ST_HB;
                end
                ST_HB: begin
                    // minute carries one hour at a time, then the hour delta
                    if (r_hpend > 3'sd0) begin
                        r_x     <= hour_ext + 12'sd1;
                        r_hpend <= r_hpend - 3'sd1;
                        r_ret   <= ST_HB;
                    end else if (r_hpend < 3'sd0) begin
                        r_x     <= hour_ext - 12'sd1;
                        r_hpend <= r_hpend + 3'sd1;
                        r_ret   <= ST_HB;
                    end else begin
                        r_x     <= hour_ext + hour_delta;
                        r_ret   <= ST_OUT;
                    end
                    r_state <= ST_NORM;
                end
                ST_NORM: begin
                    if (i_angle_mode) begin
                        r_hour  <= clamp_val;
                        r_state <= r_ret;
                    end else if (i_hour_wrap == '0) begin
                        r_hour  <= '0;
                        r_state <= r_ret;
                    end else if (fast_ok) begin
                        r_hour  <= HOURS_W'(fast_val);
                        r_state <= r_ret;
                    end else begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (mod_rsp.done) begin
                        r_hour  <= $signed({1'b0, mod_rsp.rem});
                        r_state <= r_ret;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_hours_out   <= r_hour;
                        r_minutes_out <= r_min;
                        r_seconds_out <= r_sec;
                        r_rejected    <= r_rej;
                        r_out_valid   <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hours_out   = r_hours_out;
    assign o_minutes_out = r_minutes_out;
    assign o_seconds_out = r_seconds_out;
    assign o_rejected    = r_rejected;

endmodule
